@@ design/lfs_pkg.sv @@
// Package for the LED fade step sequencer: request op codes, field widths,
// configuration register indexes and the fade command record.
// No dependencies; every other file of the block imports it.
package lfs_pkg;

  localparam int OP_W        = 2;
  localparam int IN_IDX_W    = 4;
  localparam int PORT_TIME_W = 16;
  localparam int LEVEL_W     = 8;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE  = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_DARK = '0;

  typedef struct packed {
    logic [LEVEL_W-1:0]     target;
    logic [PORT_TIME_W-1:0] dur;
    logic [IN_IDX_W-1:0]    step;
  } cmd_t;

endpackage

@@ design/lfs_in_if.sv @@
// Request channel of the LED fade step sequencer: valid/ready plus the
// request fields. Depends on lfs_pkg.
interface lfs_in_if import lfs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  op_t                    op;
  logic [IN_IDX_W-1:0]    step_index;
  logic [PORT_TIME_W-1:0] on_ms;
  logic [PORT_TIME_W-1:0] off_ms;
  logic [PORT_TIME_W-1:0] fade_ms;
  logic [LEVEL_W-1:0]     peak_level;

  modport source (output valid, op, step_index, on_ms, off_ms, fade_ms, peak_level,
                  input ready);
  modport sink (input valid, op, step_index, on_ms, off_ms, fade_ms, peak_level,
                output ready);
endinterface

@@ design/lfs_out_if.sv @@
// Fade command channel of the LED fade step sequencer: valid/ready plus
// the command fields. Depends on lfs_pkg.
interface lfs_out_if import lfs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [LEVEL_W-1:0]     fade_target;
  logic [PORT_TIME_W-1:0] fade_duration_ms;
  logic [IN_IDX_W-1:0]    step_now;

  modport source (output valid, fade_target, fade_duration_ms, step_now, input ready);
  modport sink (input valid, fade_target, fade_duration_ms, step_now, output ready);
endinterface

@@ design/led_fade_step_sequencer.sv @@
// Top level of the LED fade step sequencer: step table, phase timing and
// fade command generation. Depends on lfs_pkg, lfs_in_if and lfs_out_if.
//
//   channel   direction  handshake            payload
//   in_if     in         valid/ready          op, step_index, on/off/fade_ms, peak_level
//   out_if    out        valid/ready          fade_target, fade_duration_ms, step_now
//   cfg_*     in         cfg_we, no wait      cfg_idx, cfg_wdata
//
// One request is accepted per cycle unless the request register is stalled.
// A request is registered and processed once the result register can take
// it; its fade command (if any) is then loaded into the result register,
// which drives out_if.valid. The request register stalls only while the result
// register is full and not taken. Reset is synchronous and clears all control
// state; the step table holds no reset value and is valid only where loaded.
module led_fade_step_sequencer import lfs_pkg::*; #(
  parameter int MAX_STEPS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lfs_in_if.sink                in_if,
  lfs_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SIDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int EL_W   = TIME_BITS + 2;
  localparam int IDXC_W = 9;
  localparam logic [IDXC_W-1:0] MAX_STEPS_C = IDXC_W'(MAX_STEPS);
  localparam logic [IDXC_W-1:0] ONE_STEP    = IDXC_W'(1);
  localparam logic [EL_W-1:0]   EL_MAX      = '1;

  typedef struct packed {
    logic [TIME_BITS-1:0] on_t;
    logic [TIME_BITS-1:0] off_t;
    logic [TIME_BITS-1:0] fade_t;
    logic [LEVEL_W-1:0]   level;
  } entry_t;

  // Request register
  logic                s1_vld_r, s1_vld_nxt;
  op_t                 s1_op_r;
  logic [IN_IDX_W-1:0] s1_idx_r;
  entry_t              s1_ent_r;

  // Configuration
  logic [CNT_W-1:0] step_count_r;
  logic             loop_mode_r;

  // Sequencer state
  entry_t            tbl_r [MAX_STEPS];
  entry_t            cur_r, cur_nxt;
  logic [SIDX_W-1:0] cs_r, cs_nxt;
  logic [EL_W-1:0]   el_r, el_nxt;
  logic              run_r, run_nxt;
  logic              stop_r, stop_nxt;
  logic              fos_r, fos_nxt;
  logic              trdy_r, trdy_nxt;

  // Result register
  logic out_vld_r, out_vld_nxt;
  cmd_t out_cmd_r, cmd_nxt;

  logic              in_acc, go, emit, tbl_we, ld_in_range, is_last;
  logic [IDXC_W-1:0] ld_idx_w, cnt_eff, cs_p1;
  logic [SIDX_W-1:0] ld_idx, nidx;
  logic [EL_W-1:0]   el_inc, hold_end, step_end;
  entry_t            ent0, nent;

  assign go          = s1_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !s1_vld_r || go;
  assign in_acc      = in_if.valid && in_if.ready;
  assign s1_vld_nxt  = in_acc ? 1'b1 : (go ? 1'b0 : s1_vld_r);

  assign ld_idx_w    = IDXC_W'(s1_idx_r);
  assign ld_in_range = ld_idx_w < MAX_STEPS_C;
  assign ld_idx      = ld_idx_w[SIDX_W-1:0];

  assign ent0 = tbl_r[0];
  assign nidx = cs_r + 1'b1;
  assign nent = tbl_r[nidx];

  assign el_inc   = (el_r == EL_MAX) ? el_r : el_r + 1'b1;
  assign hold_end = EL_W'(cur_r.on_t) + EL_W'(cur_r.fade_t);
  assign step_end = EL_W'(cur_r.on_t) + (EL_W'(cur_r.fade_t) << 1) + EL_W'(cur_r.off_t);

  // A step count of zero acts as one; counts above the table size clip to it.
  always_comb begin
    if (step_count_r == '0) begin
      cnt_eff = ONE_STEP;
    end else if (IDXC_W'(step_count_r) > MAX_STEPS_C) begin
      cnt_eff = MAX_STEPS_C;
    end else begin
      cnt_eff = IDXC_W'(step_count_r);
    end
  end

  assign cs_p1   = IDXC_W'(cs_r) + ONE_STEP;
  assign is_last = (cs_p1 >= cnt_eff) || stop_r;

  always_comb begin
    cs_nxt   = cs_r;
    el_nxt   = el_r;
    run_nxt  = run_r;
    stop_nxt = stop_r;
    fos_nxt  = fos_r;
    trdy_nxt = trdy_r;
    cur_nxt  = cur_r;
    tbl_we   = 1'b0;
    emit     = 1'b0;
    cmd_nxt  = '{target: ent0.level, dur: PORT_TIME_W'(ent0.fade_t), step: '0};
    if (go) begin
      case (s1_op_r)
        OP_LOAD: begin
          if (ld_in_range) begin
            tbl_we   = 1'b1;
            trdy_nxt = 1'b1;
            // A load into the running step takes effect at once.
            if (cs_r == ld_idx) begin
              cur_nxt = s1_ent_r;
            end
          end
        end
        OP_START: begin
          if (!run_r && trdy_r) begin
            stop_nxt = 1'b0;
            run_nxt  = 1'b1;
            cs_nxt   = '0;
            el_nxt   = '0;
            fos_nxt  = 1'b0;
            cur_nxt  = ent0;
            emit     = 1'b1;
          end
        end
        OP_STOP: begin
          stop_nxt = 1'b1;
        end
        OP_TICK: begin
          if (run_r) begin
            el_nxt = el_inc;
            if (el_inc >= hold_end) begin
              if (!fos_r) begin
                fos_nxt = 1'b1;
                emit    = 1'b1;
                cmd_nxt = '{target: LEVEL_DARK, dur: PORT_TIME_W'(cur_r.fade_t),
                            step: IN_IDX_W'(cs_r)};
              end else if (el_inc >= step_end) begin
                if (is_last) begin
                  if (!stop_r && loop_mode_r) begin
                    cs_nxt  = '0;
                    el_nxt  = '0;
                    fos_nxt = 1'b0;
                    cur_nxt = ent0;
                    emit    = 1'b1;
                  end else begin
                    run_nxt = 1'b0;
                  end
                end else begin
                  cs_nxt  = nidx;
                  el_nxt  = '0;
                  fos_nxt = 1'b0;
                  cur_nxt = nent;
                  emit    = 1'b1;
                  cmd_nxt = '{target: nent.level, dur: PORT_TIME_W'(nent.fade_t),
                              step: IN_IDX_W'(nidx)};
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (go) begin
      out_vld_nxt = emit;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      step_count_r <= CNT_W'(1);
      loop_mode_r  <= 1'b0;
      cs_r         <= '0;
      el_r         <= '0;
      run_r        <= 1'b0;
      stop_r       <= 1'b0;
      fos_r        <= 1'b0;
      trdy_r       <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      cs_r      <= cs_nxt;
      el_r      <= el_nxt;
      run_r     <= run_nxt;
      stop_r    <= stop_nxt;
      fos_r     <= fos_nxt;
      trdy_r    <= trdy_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_STEP_COUNT: step_count_r <= cfg_wdata;
          CFG_LOOP_MODE:  loop_mode_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_if.op;
      s1_idx_r <= in_if.step_index;
      s1_ent_r <= '{on_t: TIME_BITS'(in_if.on_ms), off_t: TIME_BITS'(in_if.off_ms),
                    fade_t: TIME_BITS'(in_if.fade_ms), level: in_if.peak_level};
    end
    if (tbl_we) begin
      tbl_r[ld_idx] <= s1_ent_r;
    end
    cur_r <= cur_nxt;
    if (go && emit) begin
      out_cmd_r <= cmd_nxt;
    end
  end

  assign out_if.valid            = out_vld_r;
  assign out_if.fade_target      = out_cmd_r.target;
  assign out_if.fade_duration_ms = out_cmd_r.dur;
  assign out_if.step_now         = out_cmd_r.step;

endmodule

@@ design/lfs_checker.sv @@
// Port-level checks for the LED fade step sequencer and the bind that
// attaches them to the top level. Depends on lfs_pkg.
module lfs_checker import lfs_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [LEVEL_W-1:0]     out_fade_target,
  input logic [PORT_TIME_W-1:0] out_fade_duration_ms,
  input logic [IN_IDX_W-1:0]    out_step_now
);

  // After reset the result register is empty and requests are taken.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending or request blocked after reset");

  // Requests are only held back by a full result register that is not taken.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request blocked without a stalled result");

  // A fresh result is only loaded in a cycle in which the request side moved.
  a_rise_moves: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_ready))
    else $error("result appeared while the request stage was stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fade_target)
      && $stable(out_fade_duration_ms) && $stable(out_step_now))
    else $error("stalled result changed");

endmodule

bind led_fade_step_sequencer lfs_checker u_lfs_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_if.valid),
  .in_ready             (in_if.ready),
  .out_valid            (out_if.valid),
  .out_ready            (out_if.ready),
  .out_fade_target      (out_if.fade_target),
  .out_fade_duration_ms (out_if.fade_duration_ms),
  .out_step_now         (out_if.step_now)
);

@@ dv/tb_led_fade_step_sequencer.sv @@
// Testbench for led_fade_step_sequencer: drives load, start, stop and tick requests
// and register writes, predicts every fade command and checks the command channel.
// Depends on lfs_pkg, lfs_in_if, lfs_out_if and the block itself.
module tb_led_fade_step_sequencer;
  import lfs_pkg::*;

  localparam int N_STEPS        = 16;
  localparam int ELAPSED_TOP    = (1 << (PORT_TIME_W + 2)) - 1;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_REQS     = 130;

  localparam int GAP_PCT [4]   = '{0, 74, 0, 27};
  localparam int STALL_PCT [4] = '{0, 0, 74, 27};
  localparam int COUNT_SET [4] = '{4, 31, 0, 16};
  localparam int LOOP_SET [4]  = '{1, 0, 1, 1};

  typedef struct packed {
    op_t                    op;
    logic [IN_IDX_W-1:0]    step_index;
    logic [PORT_TIME_W-1:0] on_ms;
    logic [PORT_TIME_W-1:0] off_ms;
    logic [PORT_TIME_W-1:0] fade_ms;
    logic [LEVEL_W-1:0]     peak_level;
  } req_t;

  // Follows the sequencer state request by request and holds the fade commands
  // that are still owed on the command channel.
  class fade_cmd_board;
    logic [PORT_TIME_W-1:0] on_tab [N_STEPS];
    logic [PORT_TIME_W-1:0] off_tab [N_STEPS];
    logic [PORT_TIME_W-1:0] fade_tab [N_STEPS];
    logic [LEVEL_W-1:0]     level_tab [N_STEPS];
    int unsigned            step_cnt;
    bit                     loop_on;
    int unsigned            cur;
    int unsigned            elapsed;
    bit                     running;
    bit                     stop_req;
    bit                     fade_out_done;
    bit                     loaded;
    cmd_t                   expected_cmds [$];
    int                     fail_count;
    int                     cmds_checked;

    function new();
      step_cnt      = 1;
      loop_on       = 1'b0;
      cur           = 0;
      elapsed       = 0;
      running       = 1'b0;
      stop_req      = 1'b0;
      fade_out_done = 1'b0;
      loaded        = 1'b0;
      fail_count    = 0;
      cmds_checked  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_STEP_COUNT) begin
        step_cnt = 32'(val);
      end else begin
        loop_on = val[0];
      end
    endfunction

    function void enter_step(int unsigned idx);
      cmd_t c;
      cur           = idx;
      elapsed       = 0;
      fade_out_done = 1'b0;
      c.target      = level_tab[idx];
      c.dur         = fade_tab[idx];
      c.step        = idx[IN_IDX_W-1:0];
      expected_cmds.push_back(c);
    endfunction

    function void note_request(req_t r);
      int unsigned hold_end;
      int unsigned step_end;
      int unsigned in_use;
      cmd_t        c;
      case (r.op)
        OP_LOAD: begin
          on_tab[r.step_index]    = r.on_ms;
          off_tab[r.step_index]   = r.off_ms;
          fade_tab[r.step_index]  = r.fade_ms;
          level_tab[r.step_index] = r.peak_level;
          loaded = 1'b1;
        end
        OP_START: begin
          if (!running && loaded) begin
            stop_req = 1'b0;
            running  = 1'b1;
            enter_step(0);
          end
        end
        OP_STOP: stop_req = 1'b1;
        default: begin
          if (running) begin
            if (elapsed < ELAPSED_TOP) elapsed++;
            hold_end = 32'(on_tab[cur]) + 32'(fade_tab[cur]);
            step_end = hold_end + 32'(fade_tab[cur]) + 32'(off_tab[cur]);
            in_use   = (step_cnt == 0) ? 1 : (step_cnt > N_STEPS) ? N_STEPS : step_cnt;
            if (elapsed >= hold_end) begin
              if (!fade_out_done) begin
                fade_out_done = 1'b1;
                c.target = LEVEL_DARK;
                c.dur    = fade_tab[cur];
                c.step   = cur[IN_IDX_W-1:0];
                expected_cmds.push_back(c);
              end else if (elapsed >= step_end) begin
                // A pending stop or the last step ends the run; loop mode restarts it unless a stop is pending.
                if (cur + 1 >= in_use || stop_req) begin
                  running = 1'b0;
                  if (!stop_req && loop_on) begin
                    running = 1'b1;
                    enter_step(0);
                  end
                end else begin
                  enter_step(cur + 1);
                end
              end
            end
          end
        end
      endcase
    endfunction

    function void check_command(cmd_t got);
      cmd_t want;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected fade command, expected none, got target=%0d dur=%0d step=%0d",
                 $time, got.target, got.dur, got.step);
        fail_count++;
        return;
      end
      want = expected_cmds.pop_front();
      cmds_checked++;
      if (got.target !== want.target) begin
        $display("%0t: fade_target expected %0d, got %0d", $time, want.target, got.target);
        fail_count++;
      end
      if (got.dur !== want.dur) begin
        $display("%0t: fade_duration_ms expected %0d, got %0d", $time, want.dur, got.dur);
        fail_count++;
      end
      if (got.step !== want.step) begin
        $display("%0t: step_now expected %0d, got %0d", $time, want.step, got.step);
        fail_count++;
      end
    endfunction

    function int outstanding();
      return expected_cmds.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    send_gap_pct = 0;
  int                    stall_pct = 0;
  int                    idle_cycles = 0;
  fade_cmd_board         board;
  req_t                  seen_req;
  cmd_t                  seen_cmd;

  lfs_in_if  in_ch ();
  lfs_out_if out_ch ();

  led_fade_step_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_req.op         = in_ch.op;
      seen_req.step_index = in_ch.step_index;
      seen_req.on_ms      = in_ch.on_ms;
      seen_req.off_ms     = in_ch.off_ms;
      seen_req.fade_ms    = in_ch.fade_ms;
      seen_req.peak_level = in_ch.peak_level;
      board.note_request(seen_req);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_cmd.target = out_ch.fade_target;
      seen_cmd.dur    = out_ch.fade_duration_ms;
      seen_cmd.step   = out_ch.step_now;
      board.check_command(seen_cmd);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input op_t op, input logic [IN_IDX_W-1:0] idx,
                          input logic [PORT_TIME_W-1:0] on_v,
                          input logic [PORT_TIME_W-1:0] off_v,
                          input logic [PORT_TIME_W-1:0] fade_v,
                          input logic [LEVEL_W-1:0] lvl);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.step_index <= idx;
    in_ch.on_ms      <= on_v;
    in_ch.off_ms     <= off_v;
    in_ch.fade_ms    <= fade_v;
    in_ch.peak_level <= lvl;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Ticks carry random data in the fields they do not use.
  task automatic tick_n(input int n);
    repeat (n) begin
      send_req(OP_TICK, IN_IDX_W'($urandom), PORT_TIME_W'($urandom), PORT_TIME_W'($urandom),
               PORT_TIME_W'($urandom), LEVEL_W'($urandom));
    end
  endtask

  function automatic logic [PORT_TIME_W-1:0] short_time();
    if ($urandom_range(0, 9) == 0) return PORT_TIME_W'($urandom_range(5, 20));
    return PORT_TIME_W'($urandom_range(0, 4));
  endfunction

  task automatic send_random_req();
    int unsigned            pick;
    op_t                    op;
    logic [PORT_TIME_W-1:0] on_v;
    logic [PORT_TIME_W-1:0] off_v;
    logic [PORT_TIME_W-1:0] fade_v;
    pick   = $urandom_range(0, 99);
    on_v   = PORT_TIME_W'($urandom);
    off_v  = PORT_TIME_W'($urandom);
    fade_v = PORT_TIME_W'($urandom);
    if (pick < 80) begin
      op = OP_TICK;
    end else if (pick < 90) begin
      op     = OP_LOAD;
      on_v   = short_time();
      off_v  = short_time();
      fade_v = short_time();
    end else if (pick < 97) begin
      op = OP_START;
    end else begin
      op = OP_STOP;
    end
    send_req(op, IN_IDX_W'($urandom), on_v, off_v, fade_v, LEVEL_W'($urandom));
  endtask

  // Holds requests back until every owed command has come, then lets the
  // pipeline empty of requests that produce nothing.
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [CFG_DATA_W-1:0] count, input logic loop_v);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_STEP_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    board.write_reg(CFG_STEP_COUNT, count);
    cfg_idx   <= CFG_LOOP_MODE;
    cfg_wdata <= CFG_DATA_W'(loop_v);
    @(posedge clk);
    board.write_reg(CFG_LOOP_MODE, CFG_DATA_W'(loop_v));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ph;
    int n;
    board = new();
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_STEP_COUNT;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_TICK;
    in_ch.step_index <= '0;
    in_ch.on_ms      <= '0;
    in_ch.off_ms     <= '0;
    in_ch.fade_ms    <= '0;
    in_ch.peak_level <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Idle requests: tick and start are ignored, stop only arms the pending flag.
    tick_n(1);
    send_req(OP_START, '0, '0, '0, '0, '0);
    send_req(OP_STOP, '1, '1, '1, '1, '1);
    send_req(OP_LOAD, '1, '1, '1, '1, '1);
    // Zero fade and off time: fade out one tick in, step ends the tick after.
    send_req(OP_LOAD, '0, '0, '0, '0, '0);
    send_req(OP_START, '0, '0, '0, '0, '0);
    send_req(OP_START, '1, '1, '1, '1, '1);
    tick_n(2);
    send_req(OP_LOAD, 4'd0, 16'd1, 16'd0, 16'd1, 8'h5a);
    send_req(OP_LOAD, 4'd1, 16'd0, 16'd1, 16'd2, 8'ha5);
    drain_and_settle();
    set_mode(5'd2, 1'b1);
    send_req(OP_START, '0, '0, '0, '0, '0);
    tick_n(8);
    // Stop while running, then rewrite the step in progress.
    send_req(OP_STOP, '0, '0, '0, '0, '0);
    send_req(OP_LOAD, 4'd0, 16'd2, 16'd1, 16'd0, 8'h3c);
    tick_n(4);

    // Every entry gets short times before a run can reach it.
    for (n = 0; n < N_STEPS; n++) begin
      send_req(OP_LOAD, IN_IDX_W'(n), short_time(), short_time(), short_time(),
               LEVEL_W'($urandom));
    end

    for (ph = 0; ph < 4; ph++) begin
      drain_and_settle();
      send_gap_pct = GAP_PCT[ph];
      stall_pct    = STALL_PCT[ph];
      set_mode(CFG_DATA_W'(COUNT_SET[ph]), LOOP_SET[ph] != 0);
      for (n = 0; n < PHASE_REQS; n++) begin
        if (n == PHASE_REQS / 2) begin
          drain_and_settle();
          if (ph == 3) set_mode(5'd2, 1'b1);
        end
        send_random_req();
      end
    end

    drain_and_settle();
    if (board.fail_count == 0 && board.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ led_fade_step_sequencer.f @@
design/lfs_pkg.sv
design/lfs_in_if.sv
design/lfs_out_if.sv
design/led_fade_step_sequencer.sv
design/lfs_checker.sv
dv/tb_led_fade_step_sequencer.sv
